// ===== sv/cspa_pkg.sv =====
// Shared types and codes for the command slot pool allocator.
// Holds the command and result transaction structs and the action and status codes.
// Depends on nothing.
`default_nettype none

package cspa_pkg;

  localparam int unsigned GEN_W = 32;
  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned FREE_FIELD_W = 7;

  localparam logic [GEN_W-1:0] GEN_MAX = 32'hffff_ffff;
  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

  localparam logic [2:0] ACT_ACQUIRE = 3'd0;
  localparam logic [2:0] ACT_SUBMIT = 3'd1;
  localparam logic [2:0] ACT_FENCE = 3'd2;
  localparam logic [2:0] ACT_QUERY = 3'd3;
  localparam logic [2:0] ACT_PURGE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_NOTENC = 2'd2;

  typedef struct packed {
    logic [2:0]              action;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [GEN_W-1:0]        generation;
    logic                    fast_check;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_FIELD_W-1:0] out_slot;
    logic [GEN_W-1:0]        out_generation;
    logic                    ready_res;
    logic [FREE_FIELD_W-1:0] free_count;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/cspa_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module cspa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cspa_prio_enc.sv =====
// Lowest-index priority encoder over the slot request vector.
// Depends on nothing.
`default_nettype none

module cspa_prio_enc #(
  parameter int unsigned WIDTH = 64,
  localparam int unsigned IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  wire logic [WIDTH-1:0] req_i,
  output logic                  found_o,
  output logic      [IDX_W-1:0] idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        found_o = 1'b1;
        idx_o = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/command_slot_pool_allocator.sv =====
// Command slot pool allocator: every transaction is accepted, executed in the next cycle and
// its result is strobed on done_o for one cycle right after that.
// No new transaction is taken while one executes; busy_o covers the cycle in which the
// generation memory read returns and the slot flags are updated.
// Reset clears all slot flags, sets the submit counter to one and the free count to the pool
// size; the generation memory is not cleared, since an entry is only used after an acquire.
// Depends on cspa_pkg, cspa_ram and cspa_prio_enc.
`default_nettype none

module command_slot_pool_allocator #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire cspa_pkg::cmd_t cmd_i,
  output logic              busy_o,
  output logic              done_o,
  output cspa_pkg::res_t    res_o
);

  localparam int unsigned SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);

  logic                  busy_q, done_q;
  cspa_pkg::cmd_t        cmd_q;
  cspa_pkg::res_t        res_q, res_d;
  logic [POOL_SLOTS-1:0] in_use_q, in_use_d;
  logic [POOL_SLOTS-1:0] enc_q, enc_d;
  logic [POOL_SLOTS-1:0] fence_q, fence_d;
  logic [CNT_W-1:0]      free_q, free_d;
  logic [CNT_W-1:0]      retired_q, retired_d;
  logic [31:0]           counter_q, counter_d;

  logic                  accept;
  logic                  slot_valid;
  logic [SLOT_W-1:0]     sidx;
  logic [POOL_SLOTS-1:0] retire_mask;
  logic [POOL_SLOTS-1:0] cand;
  logic                  free_zero;
  logic                  pick_found;
  logic [SLOT_W-1:0]     pick_idx;
  logic                  ram_we;
  logic [31:0]           rd_gen;

  assign accept = start_i & ~busy_q;
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o = res_q;

  assign slot_valid = ({3'b000, cmd_q.slot} < 9'(POOL_SLOTS));
  assign sidx = SLOT_W'(cmd_q.slot);
  assign retire_mask = in_use_q & ~enc_q & fence_q;
  assign free_zero = (free_q == '0);
  assign cand = ~in_use_q | (free_zero ? retire_mask : '0);

  cspa_prio_enc #(
    .WIDTH(POOL_SLOTS)
  ) u_pick (
    .req_i  (cand),
    .found_o(pick_found),
    .idx_o  (pick_idx)
  );

  cspa_ram #(
    .WIDTH(32),
    .DEPTH(POOL_SLOTS)
  ) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pick_idx),
    .wdata_i(counter_q),
    .re_i   (accept),
    .raddr_i(SLOT_W'(cmd_i.slot)),
    .rdata_o(rd_gen)
  );

  always_comb begin
    in_use_d = in_use_q;
    enc_d = enc_q;
    fence_d = fence_q;
    free_d = free_q;
    retired_d = retired_q;
    counter_d = counter_q;
    ram_we = 1'b0;
    res_d = '0;
    res_d.status = cspa_pkg::ST_OK;
    if (busy_q) begin
      case (cmd_q.action)
        cspa_pkg::ACT_ACQUIRE: begin
          if (free_zero) begin
            in_use_d = in_use_q & ~retire_mask;
            fence_d = fence_q & ~retire_mask;
            free_d = retired_q;
            retired_d = '0;
          end
          if (pick_found) begin
            in_use_d[pick_idx] = 1'b1;
            enc_d[pick_idx] = 1'b1;
            fence_d[pick_idx] = 1'b0;
            free_d = free_d - CNT_W'(1);
            ram_we = 1'b1;
            res_d.out_slot = cspa_pkg::SLOT_FIELD_W'(pick_idx);
            res_d.out_generation = counter_q;
          end else begin
            res_d.status = cspa_pkg::ST_NOFREE;
          end
        end
        cspa_pkg::ACT_SUBMIT: begin
          if (slot_valid && in_use_q[sidx] && enc_q[sidx]) begin
            enc_d[sidx] = 1'b0;
            counter_d = (counter_q == cspa_pkg::GEN_MAX) ? cspa_pkg::GEN_FIRST
                                                        : counter_q + 32'd1;
            res_d.out_slot = cmd_q.slot;
            res_d.out_generation = rd_gen;
          end else begin
            res_d.status = cspa_pkg::ST_NOTENC;
          end
        end
        cspa_pkg::ACT_FENCE: begin
          if (slot_valid && in_use_q[sidx] && !enc_q[sidx]) begin
            fence_d[sidx] = 1'b1;
            if (!fence_q[sidx]) begin
              retired_d = retired_q + CNT_W'(1);
            end
          end
        end
        cspa_pkg::ACT_QUERY: begin
          if (cmd_q.generation == '0 || !slot_valid || !in_use_q[sidx] ||
              rd_gen != cmd_q.generation) begin
            res_d.ready_res = 1'b1;
          end else if (cmd_q.fast_check) begin
            res_d.ready_res = 1'b0;
          end else begin
            res_d.ready_res = fence_q[sidx];
          end
        end
        cspa_pkg::ACT_PURGE: begin
          in_use_d = in_use_q & ~retire_mask;
          fence_d = fence_q & ~retire_mask;
          free_d = free_q + retired_q;
          retired_d = '0;
        end
        default: begin
        end
      endcase
    end
    res_d.free_count = cspa_pkg::FREE_FIELD_W'(free_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      in_use_q <= '0;
      enc_q <= '0;
      fence_q <= '0;
      free_q <= CNT_W'(POOL_SLOTS);
      retired_q <= '0;
      counter_q <= cspa_pkg::GEN_FIRST;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      in_use_q <= in_use_d;
      enc_q <= enc_d;
      fence_q <= fence_d;
      free_q <= free_d;
      retired_q <= retired_d;
      counter_q <= counter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (busy_q) begin
      res_q <= res_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_o && done_o))
    else $error("busy and done are high in the same cycle");

  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o && !busy_o)
    else $error("an executing transaction did not deliver its result");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, free_q} + {1'b0, retired_q}) <= (CNT_W + 1)'(POOL_SLOTS))
    else $error("free and retired slot counts exceed the pool size");

  a_counter_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counter_q != '0)
    else $error("submit counter reached zero");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/cspa_result_checker.sv =====
// Result checker for the command slot pool allocator: watches the command and result channels,
// predicts every result from its own copy of the slot pool and compares field by field.
// Depends on cspa_pkg.
module cspa_result_checker #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  cspa_pkg::cmd_t   cmd_i,
  input  logic             done_i,
  input  cspa_pkg::res_t   res_i,
  output int unsigned      err_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  logic                       in_use [POOL_SLOTS];
  logic                       encoding [POOL_SLOTS];
  logic                       fence_seen [POOL_SLOTS];
  logic [cspa_pkg::GEN_W-1:0] stamped_gen [POOL_SLOTS];
  logic [cspa_pkg::GEN_W-1:0] submit_ctr;
  int unsigned                free_slots;
  cspa_pkg::res_t             expected_res_q[$];
  cspa_pkg::res_t             want_r;
  int unsigned                mismatch_cnt = 0;

  assign err_count_o = mismatch_cnt;

  function automatic void retire_fenced();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (in_use[i] && !encoding[i] && fence_seen[i]) begin
        in_use[i] = 1'b0;
        fence_seen[i] = 1'b0;
        free_slots++;
      end
    end
  endfunction

  function automatic cspa_pkg::res_t pool_step(input cspa_pkg::cmd_t c);
    cspa_pkg::res_t r;
    logic           taken;
    logic           in_range;
    int unsigned    s;
    r = '0;
    r.status = cspa_pkg::ST_OK;
    taken = 1'b0;
    in_range = (c.slot < POOL_SLOTS);
    s = in_range ? int'(c.slot) : 0;
    case (c.action)
      cspa_pkg::ACT_ACQUIRE: begin
        if (free_slots == 0) begin
          retire_fenced();
        end
        r.status = cspa_pkg::ST_NOFREE;
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (!taken && !in_use[i]) begin
            taken = 1'b1;
            in_use[i] = 1'b1;
            encoding[i] = 1'b1;
            fence_seen[i] = 1'b0;
            stamped_gen[i] = submit_ctr;
            if (free_slots > 0) begin
              free_slots--;
            end
            r.status = cspa_pkg::ST_OK;
            r.out_slot = cspa_pkg::SLOT_FIELD_W'(i);
            r.out_generation = submit_ctr;
          end
        end
      end
      cspa_pkg::ACT_SUBMIT: begin
        if (in_range && in_use[s] && encoding[s]) begin
          encoding[s] = 1'b0;
          if (submit_ctr == cspa_pkg::GEN_MAX) begin
            submit_ctr = cspa_pkg::GEN_FIRST;
          end else begin
            submit_ctr = submit_ctr + 1'b1;
          end
          r.out_slot = cspa_pkg::SLOT_FIELD_W'(s);
          r.out_generation = stamped_gen[s];
        end else begin
          r.status = cspa_pkg::ST_NOTENC;
        end
      end
      cspa_pkg::ACT_FENCE: begin
        if (in_range && in_use[s] && !encoding[s]) begin
          fence_seen[s] = 1'b1;
        end
      end
      cspa_pkg::ACT_QUERY: begin
        if (c.generation == '0 || !in_range || !in_use[s] || stamped_gen[s] != c.generation) begin
          r.ready_res = 1'b1;
        end else if (c.fast_check) begin
          r.ready_res = 1'b0;
        end else begin
          r.ready_res = fence_seen[s];
        end
      end
      cspa_pkg::ACT_PURGE: begin
        retire_fenced();
      end
      default: begin
      end
    endcase
    r.free_count = cspa_pkg::FREE_FIELD_W'(free_slots);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        in_use[i] = 1'b0;
        encoding[i] = 1'b0;
        fence_seen[i] = 1'b0;
        stamped_gen[i] = '0;
      end
      submit_ctr = cspa_pkg::GEN_FIRST;
      free_slots = POOL_SLOTS;
      expected_res_q.delete();
    end else begin
      if (done_i) begin
        if (expected_res_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT) begin
            $display("%t: result with no transaction outstanding: status %0d slot %0d gen %h",
                     $realtime, res_i.status, res_i.out_slot, res_i.out_generation);
          end
        end else begin
          want_r = expected_res_q.pop_front();
          if (res_i.status !== want_r.status || res_i.out_slot !== want_r.out_slot ||
              res_i.out_generation !== want_r.out_generation ||
              res_i.ready_res !== want_r.ready_res || res_i.free_count !== want_r.free_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT) begin
              $display("%t: mismatch exp status %0d slot %0d gen %h ready %0b free %0d",
                       $realtime, want_r.status, want_r.out_slot, want_r.out_generation,
                       want_r.ready_res, want_r.free_count);
              $display("%t:          got status %0d slot %0d gen %h ready %0b free %0d",
                       $realtime, res_i.status, res_i.out_slot, res_i.out_generation,
                       res_i.ready_res, res_i.free_count);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_res_q.push_back(pool_step(cmd_i));
      end
    end
    pending_o = expected_res_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the command slot pool allocator testbench: drives directed and random commands with
// random gaps, instantiates the block and the result checker and prints the verdict.
// Depends on cspa_pkg, command_slot_pool_allocator and cspa_result_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_SLOTS = 64;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned BLOCK_ITEMS = 120;
  localparam int unsigned QUIET_FIRST = 400;
  localparam int unsigned QUIET_LAST = 699;
  localparam int unsigned DRAIN_AT = 700;
  localparam int unsigned DRAIN_LIMIT = 1000;
  localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [2:0] ACT_UNDEF_MID = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} mix_mode_e;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  cspa_pkg::cmd_t cmd_i;
  logic           busy_o;
  logic           done_o;
  cspa_pkg::res_t res_o;
  int unsigned    err_count;
  int unsigned    pending;

  logic [cspa_pkg::GEN_W-1:0] known_gen [POOL_SLOTS] = '{default: '0};
  int unsigned                top_slot = 0;

  command_slot_pool_allocator #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  cspa_result_checker #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .cmd_i      (cmd_i),
    .done_i     (done_o),
    .res_i      (res_o),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Handles seen on the result channel steer later submits, fences and queries.
  always @(posedge clk_i) begin
    if (done_o && res_o.out_generation != '0) begin
      known_gen[res_o.out_slot] <= res_o.out_generation;
      if (res_o.out_slot > top_slot) begin
        top_slot <= res_o.out_slot;
      end
    end
  end

  function automatic cspa_pkg::cmd_t mk_cmd(input logic [2:0] act, input int unsigned slot,
                                            input logic [cspa_pkg::GEN_W-1:0] gen,
                                            input logic fast);
    cspa_pkg::cmd_t c;
    c.action = act;
    c.slot = cspa_pkg::SLOT_FIELD_W'(slot);
    c.generation = gen;
    c.fast_check = fast;
    return c;
  endfunction

  function automatic cspa_pkg::cmd_t rand_cmd(input mix_mode_e mode);
    cspa_pkg::cmd_t c;
    int unsigned    roll;
    int unsigned    pick;
    int unsigned    w_acq;
    int unsigned    w_sub;
    int unsigned    w_fen;
    int unsigned    w_qry;
    c.fast_check = 1'($urandom_range(0, 1));
    c.generation = $urandom;
    case (mode)
      MODE_FILL: begin
        w_acq = 45; w_sub = 25; w_fen = 10; w_qry = 12;
      end
      MODE_MIX: begin
        w_acq = 25; w_sub = 25; w_fen = 20; w_qry = 20;
      end
      default: begin
        w_acq = 8; w_sub = 15; w_fen = 35; w_qry = 27;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      c.action = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
    end else if (roll < 3 + w_acq) begin
      c.action = cspa_pkg::ACT_ACQUIRE;
    end else if (roll < 3 + w_acq + w_sub) begin
      c.action = cspa_pkg::ACT_SUBMIT;
    end else if (roll < 3 + w_acq + w_sub + w_fen) begin
      c.action = cspa_pkg::ACT_FENCE;
    end else if (roll < 3 + w_acq + w_sub + w_fen + w_qry) begin
      c.action = cspa_pkg::ACT_QUERY;
    end else begin
      c.action = cspa_pkg::ACT_PURGE;
    end
    if ($urandom_range(0, 9) < 8) begin
      c.slot = cspa_pkg::SLOT_FIELD_W'($urandom_range(0, top_slot));
    end else begin
      c.slot = cspa_pkg::SLOT_FIELD_W'($urandom_range(0, POOL_SLOTS - 1));
    end
    if (c.action == cspa_pkg::ACT_QUERY) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        c.generation = known_gen[c.slot];
      end else if (pick == 6) begin
        c.generation = '0;
      end else if (pick == 7) begin
        c.generation = known_gen[c.slot] + 1'b1;
      end else if (pick == 8) begin
        c.generation = cspa_pkg::GEN_MAX;
      end
    end
    return c;
  endfunction

  task automatic send_cmd(input cspa_pkg::cmd_t c);
    @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i <= c;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      cmd_i <= mk_cmd(3'($urandom), $urandom, $urandom, 1'($urandom));
    end
  endtask

  initial begin
    cspa_pkg::cmd_t dir_q[$];
    int unsigned    guard;
    mix_mode_e      mode;
    start_i = 1'b0;
    cmd_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, POOL_SLOTS - 1, cspa_pkg::GEN_MAX, 1'b1));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_SUBMIT, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_FENCE, 5, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_PURGE, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(ACT_UNDEF_LO, POOL_SLOTS - 1, cspa_pkg::GEN_MAX, 1'b1));
    dir_q.push_back(mk_cmd(ACT_UNDEF_HI, 21, 32'h5555_5555, 1'b0));
    dir_q.push_back(mk_cmd(ACT_UNDEF_MID, 42, 32'haaaa_aaaa, 1'b1));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_ACQUIRE, POOL_SLOTS - 1, cspa_pkg::GEN_MAX, 1'b1));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_ACQUIRE, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, cspa_pkg::GEN_FIRST, 1'b1));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, cspa_pkg::GEN_FIRST, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_FENCE, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_SUBMIT, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_SUBMIT, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, cspa_pkg::GEN_FIRST, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_FENCE, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, cspa_pkg::GEN_FIRST, 1'b1));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, cspa_pkg::GEN_FIRST, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, cspa_pkg::GEN_FIRST + 1'b1, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_ACQUIRE, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_PURGE, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_QUERY, 0, cspa_pkg::GEN_FIRST, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_ACQUIRE, 0, '0, 1'b0));
    dir_q.push_back(mk_cmd(cspa_pkg::ACT_SUBMIT, 1, '0, 1'b0));
    foreach (dir_q[i]) begin
      send_cmd(dir_q[i]);
    end

    // Modes rotate so the pool fills up to exhaustion, churns and drains again.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      mode = mix_mode_e'((n / BLOCK_ITEMS) % 3);
      if (n == DRAIN_AT) begin
        while (pending != 0) begin
          idle_cycles(1);
        end
      end else if ((n < QUIET_FIRST || n > QUIET_LAST) && $urandom_range(0, 99) < 15) begin
        idle_cycles($urandom_range(1, 4));
      end
      send_cmd(rand_cmd(mode));
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cspa_pkg.sv
sv/cspa_ram.sv
sv/cspa_prio_enc.sv
sv/command_slot_pool_allocator.sv
tb/sv/cspa_result_checker.sv
tb/sv/tb_top.sv
